// File: design/id_keyed_bump_region_allocator_core_assert.svh
// assertion helpers used by the allocator control module
`ifndef ID_KEYED_BUMP_REGION_ALLOCATOR_CORE_ASSERT_SVH
`define ID_KEYED_BUMP_REGION_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define IKBRA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// next-cycle implication, disabled while in reset
`define IKBRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// File: design/ikbra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ikbra_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned AddrW      = 48;
  localparam int unsigned IdW        = 32;
  localparam int unsigned BytesW     = 32;
  localparam int unsigned LimitW     = 5;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 48;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StZeroId   = 3'd1,
    StDuplicate = 3'd2,
    StFull     = 3'd3,
    StNoSpace  = 3'd4,
    StNotFound = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPoolBase   = 3'd0,
    CfgPoolBytes  = 3'd1,
    CfgPhysBase   = 3'd2,
    CfgGrowUpward = 3'd3,
    CfgEntryLimit = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ModeAlloc  = 1'b0,
    ModeLookup = 1'b1
  } mode_e;

  typedef struct packed {
    logic              mode;
    logic [IdW-1:0]    region_id;
    logic [BytesW-1:0] request_bytes;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [AddrW-1:0]  virt_address;
    logic [AddrW-1:0]  phys_address;
    logic [BytesW-1:0] region_bytes;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic skip_scan;
    logic scan_done;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/ikbra_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "id_keyed_bump_region_allocator_core_assert.svh"

module ikbra_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  ikbra_pkg::dp_status_t dp_status_i,
  output ikbra_pkg::dp_cmd_t   dp_cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   go;

  // result slot is free or is being emptied this cycle
  assign go = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (dp_status_i.skip_scan || dp_status_i.scan_done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (go) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o       = (state_q == StIdle);
  assign out_valid_o      = out_valid_q;
  assign dp_cmd_o.load    = in_valid_i && (state_q == StIdle);
  assign dp_cmd_o.scan_en = (state_q == StScan);
  assign dp_cmd_o.finish  = (state_q == StFinish) && go;

  `IKBRA_ASSERT_NEXT(a_accept_starts_scan, clk_i, rst_ni,
                     in_valid_i && in_ready_o, state_q == StScan)
  `IKBRA_ASSERT_NEXT(a_finish_posts_result, clk_i, rst_ni,
                     dp_cmd_o.finish, out_valid_o && state_q == StIdle)
  `IKBRA_ASSERT_NEXT(a_scan_holds, clk_i, rst_ni,
                     state_q == StScan && !dp_status_i.skip_scan && !dp_status_i.scan_done,
                     state_q == StScan)
  `IKBRA_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni,
                    dp_cmd_o.finish, !out_valid_o || out_ready_i)

endmodule

`default_nettype wire

// File: design/ikbra_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ikbra_dp #(
  parameter int unsigned MaxEntries = ikbra_pkg::MaxEntries
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  ikbra_pkg::req_t                    req_i,
  input  wire                                cfg_valid_i,
  input  wire [ikbra_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire [ikbra_pkg::CfgDataW-1:0]      cfg_data_i,
  input  ikbra_pkg::dp_cmd_t                 dp_cmd_i,
  output ikbra_pkg::dp_status_t              dp_status_o,
  output ikbra_pkg::rsp_t                    rsp_o
);

  localparam int unsigned AW   = ikbra_pkg::AddrW;
  localparam int unsigned BW   = ikbra_pkg::BytesW;
  localparam int unsigned LW   = ikbra_pkg::LimitW;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CmpW = (CntW > LW) ? CntW : LW;

  typedef struct packed {
    logic [ikbra_pkg::IdW-1:0] id;
    logic [BW-1:0]             size;
    logic [AW-1:0]             start;
  } entry_t;

  // configuration
  logic [AW-1:0] pool_base_q, pool_base_d;
  logic [BW-1:0] pool_bytes_q, pool_bytes_d;
  logic [AW-1:0] phys_base_q, phys_base_d;
  logic          grow_q, grow_d;
  logic [LW-1:0] limit_q, limit_d;
  logic          restart;
  logic [AW:0]   restart_next;

  // allocator state
  logic [CntW-1:0] count_q;
  logic [AW:0]     next_q;
  entry_t          mem [MaxEntries];

  // request and scan
  ikbra_pkg::req_t req_q;
  logic [CntW-1:0] idx_q;
  logic            rd_vld_q;
  entry_t          rd_q;
  logic            hit_q;
  logic [BW-1:0]   hit_size_q;
  logic [AW-1:0]   hit_start_q;
  logic            scan_more;
  logic            match;

  // precomputed per request
  logic          space_ok_q;
  logic [AW-1:0] new_start_q;
  logic [AW:0]   next_after_q;
  logic [AW-1:0] delta_q;

  logic [AW:0]   size_ext;
  logic [AW:0]   pool_end;
  logic [AW+1:0] up_sum;
  logic [AW:0]   dec;
  logic          up_fail;
  logic          down_fail;
  logic          full;
  logic          zero_id;
  logic          alloc_ok;
  logic          commit;
  logic [AW-1:0] start_sel;
  ikbra_pkg::rsp_t rsp_q, rsp_d;

  always_comb begin
    pool_base_d  = pool_base_q;
    pool_bytes_d = pool_bytes_q;
    phys_base_d  = phys_base_q;
    grow_d       = grow_q;
    limit_d      = limit_q;
    restart      = 1'b0;
    if (cfg_valid_i) begin
      case (ikbra_pkg::cfg_idx_e'(cfg_index_i))
        ikbra_pkg::CfgPoolBase: begin
          pool_base_d = cfg_data_i[AW-1:0];
          restart     = 1'b1;
        end
        ikbra_pkg::CfgPoolBytes: begin
          pool_bytes_d = cfg_data_i[BW-1:0];
          restart      = 1'b1;
        end
        ikbra_pkg::CfgPhysBase: begin
          phys_base_d = cfg_data_i[AW-1:0];
        end
        ikbra_pkg::CfgGrowUpward: begin
          grow_d  = cfg_data_i[0];
          restart = 1'b1;
        end
        ikbra_pkg::CfgEntryLimit: begin
          limit_d = cfg_data_i[LW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign restart_next = grow_d ? {1'b0, pool_base_d}
                               : {1'b0, pool_base_d} + {{(AW + 1 - BW){1'b0}}, pool_bytes_d};

  // full table: count at the register limit or at the table depth
  assign full    = (CmpW'(count_q) >= CmpW'(limit_q)) || (count_q >= CntW'(MaxEntries));
  assign zero_id = (req_q.region_id == '0);

  assign scan_more = !hit_q && (idx_q < count_q);
  assign match     = rd_vld_q && !hit_q && (rd_q.id == req_q.region_id);

  assign dp_status_o.skip_scan = zero_id || ((req_q.mode == ikbra_pkg::ModeAlloc) && full);
  assign dp_status_o.scan_done = hit_q || (!scan_more && !rd_vld_q);

  // space check for the pending allocate, pointer held one bit wider
  assign size_ext  = {{(AW + 1 - BW){1'b0}}, req_q.request_bytes};
  assign pool_end  = {1'b0, pool_base_q} + {{(AW + 1 - BW){1'b0}}, pool_bytes_q};
  assign up_sum    = {1'b0, next_q} + {1'b0, size_ext};
  assign dec       = next_q - size_ext;
  assign up_fail   = up_sum > {1'b0, pool_end};
  assign down_fail = (next_q < {1'b0, pool_base_q}) || (size_ext > (next_q - {1'b0, pool_base_q}));

  always_ff @(posedge clk_i) begin
    space_ok_q   <= grow_q ? !up_fail : !down_fail;
    new_start_q  <= grow_q ? next_q[AW-1:0] : dec[AW-1:0];
    next_after_q <= grow_q ? up_sum[AW:0] : dec;
    delta_q      <= phys_base_q - pool_base_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      pool_bytes_q <= '0;
      phys_base_q  <= '0;
      grow_q       <= 1'b1;
      limit_q      <= LW'(16);
    end else begin
      pool_base_q  <= pool_base_d;
      pool_bytes_q <= pool_bytes_d;
      phys_base_q  <= phys_base_d;
      grow_q       <= grow_d;
      limit_q      <= limit_d;
    end
  end

  assign alloc_ok = !zero_id && (req_q.mode == ikbra_pkg::ModeAlloc) && !full && !hit_q
                    && space_ok_q;
  assign commit   = dp_cmd_i.finish && alloc_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      next_q  <= '0;
    end else if (restart) begin
      count_q <= '0;
      next_q  <= restart_next;
    end else if (commit) begin
      count_q <= count_q + 1'b1;
      next_q  <= next_after_q;
    end
  end

  // scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (dp_cmd_i.load) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (dp_cmd_i.scan_en) begin
      rd_vld_q <= scan_more;
      if (scan_more) begin
        idx_q <= idx_q + 1'b1;
      end
      if (match) begin
        hit_q <= 1'b1;
      end
    end
  end

  // region table, one registered read port and one write port
  always_ff @(posedge clk_i) begin
    if (commit) begin
      mem[count_q[IdxW-1:0]] <= '{id: req_q.region_id, size: req_q.request_bytes,
                                  start: new_start_q};
    end
    if (dp_cmd_i.scan_en && scan_more) begin
      rd_q <= mem[idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      req_q <= req_i;
    end
    if (dp_cmd_i.scan_en && match) begin
      hit_size_q  <= rd_q.size;
      hit_start_q <= rd_q.start;
    end
    if (dp_cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign start_sel = (req_q.mode == ikbra_pkg::ModeLookup) ? hit_start_q : new_start_q;

  always_comb begin
    rsp_d.status       = ikbra_pkg::StOk;
    rsp_d.virt_address = start_sel;
    rsp_d.phys_address = start_sel + delta_q;
    rsp_d.region_bytes = (req_q.mode == ikbra_pkg::ModeLookup) ? hit_size_q
                                                               : req_q.request_bytes;
    if (zero_id) begin
      rsp_d.status = ikbra_pkg::StZeroId;
    end else if (req_q.mode == ikbra_pkg::ModeLookup) begin
      if (!hit_q) begin
        rsp_d.status = ikbra_pkg::StNotFound;
      end
    end else if (full) begin
      rsp_d.status = ikbra_pkg::StFull;
    end else if (hit_q) begin
      rsp_d.status = ikbra_pkg::StDuplicate;
    end else if (!space_ok_q) begin
      rsp_d.status = ikbra_pkg::StNoSpace;
    end
    if (rsp_d.status != ikbra_pkg::StOk) begin
      rsp_d.virt_address = '0;
      rsp_d.phys_address = '0;
      rsp_d.region_bytes = '0;
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// File: design/id_keyed_bump_region_allocator_core.sv
// an accepted request is checked against the stored ids, one region per cycle; the scan
//   is skipped for a zero id or a full table on allocate, and nothing is scanned when
//   the table is empty; the result is registered once the output slot is free
// requests: one at a time, limited by the id scan over the single table read port
// a new request is taken while the previous result still waits at the output
// reset: asynchronous active low; table empties, pointer to pool base, registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module id_keyed_bump_region_allocator_core #(
  parameter int unsigned MaxEntries = ikbra_pkg::MaxEntries
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  ikbra_pkg::req_t                in_req_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output ikbra_pkg::rsp_t                out_rsp_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [ikbra_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [ikbra_pkg::CfgDataW-1:0]  cfg_data_i
);

  ikbra_pkg::dp_cmd_t    dp_cmd;
  ikbra_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  ikbra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  ikbra_dp #(
    .MaxEntries (MaxEntries)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .dp_cmd_i    (dp_cmd),
    .dp_status_o (dp_status),
    .rsp_o       (out_rsp_o)
  );

endmodule

`default_nettype wire
